// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file gfau_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/gfau_pkg.sv =====
// ---------------------------------------------------------------------------
// gfau_pkg
// Types and codes for the GF(256) arithmetic unit.
// ---------------------------------------------------------------------------
package gfau_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 1;

  // Opcodes
  localparam logic [OpW-1:0] OP_MUL    = 3'd0;
  localparam logic [OpW-1:0] OP_INV    = 3'd1;
  localparam logic [OpW-1:0] OP_LOG    = 3'd2;
  localparam logic [OpW-1:0] OP_EXP    = 3'd3;
  localparam logic [OpW-1:0] OP_POW111 = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FIELD_POLY_LOW = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_BASE     = 1'd1;

  // Reset values and constants
  localparam logic [ByteW-1:0] POLY_RESET  = 8'd29;
  localparam logic [ByteW-1:0] ALPHA_RESET = 8'd2;
  localparam logic [ByteW-1:0] EXP_INV     = 8'd254;
  localparam logic [ByteW-1:0] EXP_POW111  = 8'd111;
  localparam logic [ByteW-1:0] LOG_NONE    = 8'd255;
  localparam logic [ByteW-1:0] LAST_POWER  = 8'd255;
  localparam logic [ByteW-1:0] ONE         = 8'd1;

  typedef struct packed {
    logic [ByteW-1:0] poly;
    logic [ByteW-1:0] alpha;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULT,
    S_SQR,
    S_MULX,
    S_LOG,
    S_EXP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/gfau_cmd_if.sv =====
// ---------------------------------------------------------------------------
// gfau_cmd_if
// Command channel: opcode and operands, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gfau_cmd_if;
  import gfau_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [ByteW-1:0] operand_a;
  logic [ByteW-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

// ===== rtl/core/gfau_rsp_if.sv =====
// ---------------------------------------------------------------------------
// gfau_rsp_if
// Response channel: one result byte, valid/ready handshake.
// ---------------------------------------------------------------------------
interface gfau_rsp_if;
  import gfau_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink (input valid, input result_byte, output ready);
endinterface

// ===== rtl/core/gf256_arithmetic_unit.sv =====
// Multiply uses S_MULT, inverse and power 111 S_SQR and S_MULX, exp S_EXP for
// operand_a steps, log S_LOG; unused opcodes go straight to S_DONE.
// One item at a time: the single GF multiplier in gfau_core is reused each
// cycle, so log or exp of 255 (256 powers each) sets the worst case.
// Reset (synchronous, rst high) returns to idle with no result pending and
// loads field_poly_low = 29, alpha_base = 2.
// ---------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(256) multiply, inverse, log, exp and x^111 with configurable field.
// ---------------------------------------------------------------------------
module gf256_arithmetic_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gfau_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gfau_pkg::ByteW-1:0]    cfg_data,
  gfau_cmd_if.sink                      cmd,
  gfau_rsp_if.source                    rsp
);
  import gfau_pkg::*;

  cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly  <= POLY_RESET;
      cfg.alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_POLY_LOW: cfg.poly  <= cfg_data;
        REG_ALPHA_BASE:     cfg.alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  gfau_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule

// ===== rtl/core/gfau_mul.sv =====
// ---------------------------------------------------------------------------
// gfau_mul
// Shared GF(256) multiplier: shift-and-add, reduced on each carry out.
// ---------------------------------------------------------------------------
module gfau_mul (
  input  logic [gfau_pkg::ByteW-1:0] poly,
  input  logic [gfau_pkg::ByteW-1:0] a,
  input  logic [gfau_pkg::ByteW-1:0] b,
  output logic [gfau_pkg::ByteW-1:0] p
);
  import gfau_pkg::*;

  // Scan b from its top bit down
  always_comb begin
    logic [ByteW-1:0] acc;
    acc = '0;
    for (int k = ByteW - 1; k >= 0; k--) begin
      acc = acc[ByteW-1] ? ({acc[ByteW-2:0], 1'b0} ^ poly) : {acc[ByteW-2:0], 1'b0};
      if (b[k]) begin
        acc = acc ^ a;
      end
    end
    p = acc;
  end

endmodule

// ===== rtl/core/gfau_core.sv =====
// ---------------------------------------------------------------------------
// gfau_core
// Sequencer around the shared multiplier; runs one command at a time.
// ---------------------------------------------------------------------------
module gfau_core (
  input  logic           clk,
  input  logic           rst,
  input  gfau_pkg::cfg_t cfg,
  gfau_cmd_if.sink       cmd,
  gfau_rsp_if.source     rsp
);
  import gfau_pkg::*;

  state_t state, state_next;

  logic [ByteW-1:0] xa, xa_next;
  logic [ByteW-1:0] xb, xb_next;
  logic [ByteW-1:0] ex, ex_next;
  logic [2:0]       kbit, kbit_next;
  logic [ByteW-1:0] cnt, cnt_next;
  logic [ByteW-1:0] acc, acc_next;
  logic [ByteW-1:0] best, best_next;

  logic [ByteW-1:0] mul_a, mul_b, mul_p;
  logic             accept;
  logic             hit;

  assign accept = cmd.valid && cmd.ready;
  assign hit    = (acc == xa);

  assign cmd.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_DONE);
  assign rsp.result_byte = acc;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_MULT:  begin mul_a = xa;  mul_b = xb;        end
      S_MULX:  begin mul_a = acc; mul_b = xa;        end
      S_LOG,
      S_EXP:   begin mul_a = acc; mul_b = cfg.alpha; end
      default: begin mul_a = acc; mul_b = acc;       end
    endcase
  end

  gfau_mul u_mul (
    .poly (cfg.poly),
    .a    (mul_a),
    .b    (mul_b),
    .p    (mul_p)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            OP_MUL:            state_next = S_MULT;
            OP_INV, OP_POW111: state_next = S_SQR;
            OP_LOG:            state_next = S_LOG;
            OP_EXP:            state_next = S_EXP;
            default:           state_next = S_DONE;
          endcase
        end
      end
      S_MULT: state_next = S_DONE;
      S_SQR: begin
        if (ex[kbit])          state_next = S_MULX;
        else if (kbit == 3'd0) state_next = S_DONE;
      end
      S_MULX: state_next = (kbit == 3'd0) ? S_DONE : S_SQR;
      S_LOG:  if (cnt == LAST_POWER) state_next = S_DONE;
      S_EXP:  if (cnt == xa) state_next = S_DONE;
      S_DONE: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    xa_next   = xa;
    xb_next   = xb;
    ex_next   = ex;
    kbit_next = kbit;
    cnt_next  = cnt;
    acc_next  = acc;
    best_next = best;
    unique case (state)
      S_IDLE: begin
        xa_next   = cmd.operand_a;
        xb_next   = cmd.operand_b;
        kbit_next = 3'd7;
        cnt_next  = '0;
        best_next = LOG_NONE;
        acc_next  = ONE;
        ex_next   = (cmd.opcode == OP_INV) ? EXP_INV : EXP_POW111;
        if (cmd.opcode != OP_MUL && cmd.opcode != OP_INV && cmd.opcode != OP_LOG &&
            cmd.opcode != OP_EXP && cmd.opcode != OP_POW111) begin
          acc_next = '0;
        end
      end
      S_MULT: acc_next = mul_p;
      S_SQR: begin
        acc_next = mul_p;
        if (!ex[kbit] && kbit != 3'd0) kbit_next = kbit - 3'd1;
      end
      S_MULX: begin
        acc_next = mul_p;
        if (kbit != 3'd0) kbit_next = kbit - 3'd1;
      end
      S_LOG: begin
        if (hit) best_next = cnt;
        if (cnt == LAST_POWER) begin
          // last power checked: hand back the best match
          acc_next = hit ? cnt : best;
        end else begin
          acc_next = mul_p;
          cnt_next = cnt + 8'd1;
        end
      end
      S_EXP: begin
        if (cnt != xa) begin
          acc_next = mul_p;
          cnt_next = cnt + 8'd1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    xa   <= xa_next;
    xb   <= xb_next;
    ex   <= ex_next;
    kbit <= kbit_next;
    cnt  <= cnt_next;
    acc  <= acc_next;
    best <= best_next;
  end

endmodule

// ===== rtl/core/gfau_checker.sv =====
// ---------------------------------------------------------------------------
// gfau_checker
// Port-level checks on the GF(256) unit's handshakes, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gfau_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [gfau_pkg::ByteW-1:0] result_byte
);
  import gfau_pkg::*;

  logic cmd_take;
  logic rsp_take;
  logic rsp_stall;

  // Handshake terms
  assign cmd_take  = cmd_valid && cmd_ready;
  assign rsp_take  = rsp_valid && rsp_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  // One item in flight: no intake while a result is pending
  `ASSERT_CLK_RST(a_idle_no_result, clk, rst, !(cmd_ready && rsp_valid), "ready with result")

  // Accepted item blocks further intake
  `ASSERT_CLK_RST(a_busy_after_accept, clk, rst, cmd_take |=> !cmd_ready, "ready after accept")

  // Result leaves after one handshake
  `ASSERT_CLK_RST(a_result_once, clk, rst, rsp_take |=> !rsp_valid, "result repeated")

  // Stalled result stays offered
  `ASSERT_CLK_RST(a_result_hold, clk, rst, rsp_stall |=> rsp_valid, "stalled result dropped")

  // Stalled result holds its byte
  `ASSERT_CLK_RST(a_byte_hold, clk, rst, rsp_stall |=> $stable(result_byte), "byte changed")

endmodule

bind gf256_arithmetic_unit gfau_checker u_gfau_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_byte (rsp.result_byte)
);

// ===== test/tb_gf256_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// tb_gf256_arithmetic_unit
// Checks every GF(256) result of the unit against a software model of the
// field arithmetic, across reset and written field settings, with random
// idle cycles on both channels, a long output stall and a drain pause.
// ---------------------------------------------------------------------------
module tb_gf256_arithmetic_unit;
  import gfau_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned IDLE_MAX     = 14;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LATENCY_TAIL = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 150;

  // One accepted command and the byte it must produce
  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ByteW-1:0] op_a;
    logic [ByteW-1:0] op_b;
    logic [ByteW-1:0] result;
  } gf_item_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  gfau_cmd_if cmd_if ();
  gfau_rsp_if rsp_if ();

  gf256_arithmetic_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .rsp       (rsp_if)
  );

  // Field setting as the unit should hold it
  logic [ByteW-1:0] field_poly;
  logic [ByteW-1:0] alpha;

  gf_item_t    pending_results[$];
  int unsigned fail_count;
  int unsigned idle_max;
  int unsigned rsp_hold;
  int unsigned cycle_count;

  // ---------------------------------------------------------------------------
  // Field arithmetic
  // ---------------------------------------------------------------------------

  // Shift-and-add, operand b scanned from its top bit, reduced on overflow
  function automatic logic [ByteW-1:0] gf_mul(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    logic [ByteW-1:0] acc;
    logic             carry;
    acc = '0;
    for (int k = ByteW - 1; k >= 0; k--) begin
      carry = acc[ByteW-1];
      acc   = acc << 1;
      if (carry) acc ^= field_poly;
      if (b[k]) acc ^= a;
    end
    return acc;
  endfunction

  // Square-and-multiply over all eight exponent bits
  function automatic logic [ByteW-1:0] gf_pow(logic [ByteW-1:0] x, logic [ByteW-1:0] e);
    logic [ByteW-1:0] y;
    y = ONE;
    for (int k = ByteW - 1; k >= 0; k--) begin
      y = gf_mul(y, y);
      if (e[k]) y = gf_mul(y, x);
    end
    return y;
  endfunction

  // Last power of the base that matches wins; no match leaves LOG_NONE
  function automatic logic [ByteW-1:0] gf_log(logic [ByteW-1:0] x);
    logic [ByteW-1:0] p;
    logic [ByteW-1:0] best;
    p    = ONE;
    best = LOG_NONE;
    for (int i = 0; i < 256; i++) begin
      if (p == x) best = i[ByteW-1:0];
      p = gf_mul(p, alpha);
    end
    return best;
  endfunction

  function automatic logic [ByteW-1:0] gf_exp(logic [ByteW-1:0] e);
    logic [ByteW-1:0] p;
    p = ONE;
    for (int i = 0; i < int'(e); i++) p = gf_mul(p, alpha);
    return p;
  endfunction

  function automatic logic [ByteW-1:0] gf_predict(logic [OpW-1:0] op, logic [ByteW-1:0] a,
                                                  logic [ByteW-1:0] b);
    case (op)
      OP_MUL:    return gf_mul(a, b);
      OP_INV:    return gf_pow(a, EXP_INV);
      OP_LOG:    return gf_log(a);
      OP_EXP:    return gf_exp(a);
      OP_POW111: return gf_pow(a, EXP_POW111);
      default:   return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap; record its result once accepted
  task automatic send_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] a,
                           input logic [ByteW-1:0] b);
    int unsigned gap;
    gf_item_t    item;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.opcode    <= op;
    cmd_if.operand_a <= a;
    cmd_if.operand_b <= b;
    do @(posedge clk); while (!cmd_if.ready);
    item.opcode = op;
    item.op_a   = a;
    item.op_b   = b;
    item.result = gf_predict(op, a, b);
    pending_results.push_back(item);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Both registers, one per cycle; only called with the unit drained
  task automatic write_field(input logic [ByteW-1:0] poly, input logic [ByteW-1:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIELD_POLY_LOW;
    cfg_data  <= poly;
    @(posedge clk);
    cfg_index <= REG_ALPHA_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_we     <= 1'b0;
    field_poly  = poly;
    alpha       = base;
  endtask

  // Mostly random bytes, a quarter of them taken from the edges
  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'h01;
        2:       return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  // Log and exp are the slow ones, so they get a smaller share
  function automatic logic [OpW-1:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_MUL;
    if (r < 50) return OP_INV;
    if (r < 70) return OP_POW111;
    if (r < 88) return OP_EXP;
    if (r < 97) return OP_LOG;
    return OpW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  task automatic send_random_item();
    send_item(pick_opcode(), pick_byte(), pick_byte());
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per item, then compare with the oldest entry
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    gf_item_t    want;
    rsp_if.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold != 0) begin
        stall    = rsp_hold;
        rsp_hold = 0;
      end else begin
        stall = $urandom_range(0, idle_max);
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result %02h with nothing outstanding", rsp_if.result_byte);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_byte !== want.result) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch op %0d a %02h b %02h poly %02h alpha %02h: exp %02h got %02h",
                     want.opcode, want.op_a, want.op_b, field_poly, alpha, want.result,
                     rsp_if.result_byte);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edge operands for every opcode under the reset field setting
  task automatic test_directed();
    send_item(OP_MUL, 8'h00, 8'hFF);
    send_item(OP_MUL, 8'hFF, 8'hFF);
    send_item(OP_MUL, 8'h80, 8'h02);
    send_item(OP_MUL, 8'h01, 8'hA5);
    send_item(OP_MUL, 8'h57, 8'h83);
    // inverse of zero comes out as zero
    send_item(OP_INV, 8'h00, 8'h00);
    send_item(OP_INV, 8'h01, 8'hFF);
    send_item(OP_INV, 8'hFF, 8'h00);
    send_item(OP_INV, 8'h80, 8'h00);
    // log of one and of zero both give the no-match code
    send_item(OP_LOG, 8'h00, 8'h00);
    send_item(OP_LOG, 8'h01, 8'h00);
    send_item(OP_LOG, 8'h02, 8'h00);
    send_item(OP_LOG, 8'hFF, 8'h00);
    // exp of zero is one
    send_item(OP_EXP, 8'h00, 8'h00);
    send_item(OP_EXP, 8'h01, 8'h00);
    send_item(OP_EXP, 8'hFF, 8'h00);
    send_item(OP_EXP, 8'h80, 8'h00);
    send_item(OP_POW111, 8'h00, 8'h00);
    send_item(OP_POW111, 8'h01, 8'h00);
    send_item(OP_POW111, 8'hFF, 8'h00);
    // spare opcodes answer zero
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_item(OpW'(op), pick_byte(), pick_byte());
    drain_results();
  endtask

  // Long output stall with the sender still pushing, then a full drain pause
  task automatic test_backpressure();
    idle_max = 0;
    rsp_hold = HOLD_CYCLES;
    repeat (12) send_random_item();
    drain_results();
    idle_max = IDLE_MAX;
    repeat (8) send_random_item();
    drain_results();
  endtask

  // Random items under a run of field settings, extremes first
  task automatic test_random_phases();
    logic [ByteW-1:0] poly;
    logic [ByteW-1:0] base;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin poly = POLY_RESET; base = ALPHA_RESET; end
        1: begin poly = 8'h00;      base = 8'h00;       end
        2: begin poly = 8'hFF;      base = 8'hFF;       end
        3: begin poly = 8'h1B;      base = 8'h03;       end
        4: begin poly = 8'h1D;      base = 8'h80;       end
        default: begin poly = pick_byte(); base = pick_byte(); end
      endcase
      write_field(poly, base);
      // every third phase runs both sides flat out
      idle_max = (ph % 3 == 2) ? 0 : IDLE_MAX;
      repeat (PHASE_ITEMS) send_random_item();
      drain_results();
    end
    idle_max = IDLE_MAX;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_FIELD_POLY_LOW;
    cfg_data         = '0;
    cmd_if.valid     = 1'b0;
    cmd_if.opcode    = OP_MUL;
    cmd_if.operand_a = '0;
    cmd_if.operand_b = '0;
    field_poly       = POLY_RESET;
    alpha            = ALPHA_RESET;
    idle_max         = IDLE_MAX;
    rsp_hold         = 0;
    fail_count       = 0;
    cycle_count      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random_phases();

    // anything extra that shows up late is still caught by the result side
    repeat (LATENCY_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
